/* rtl/pts_pkg.sv */
// Shared types and constants for the perspective texture span unit.
package pts_pkg;
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_START = 2'd1;
  localparam logic [1:0] CMD_SHADE = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic [2:0] REG_OOZ_STEP = 3'd0;
  localparam logic [2:0] REG_UOZ_STEP = 3'd1;
  localparam logic [2:0] REG_VOZ_STEP = 3'd2;
  localparam logic [2:0] REG_WIDTH = 3'd3;
  localparam logic [2:0] REG_HEIGHT = 3'd4;
  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

  typedef struct packed {
    logic [1:0]         command;
    logic [13:0]        texel_index;
    logic [23:0]        texel_rgb;
    logic signed [31:0] start_one_over_z;
    logic signed [31:0] start_u_over_z;
    logic signed [31:0] start_v_over_z;
    logic [15:0]        x_prestep;
  } in_t;

  typedef struct packed {
    logic [31:0] pixel_argb;
    logic        coordinate_fault;
  } out_t;
endpackage

/* rtl/perspective_texture_span.sv */
// Perspective texture span top level: command sequencer, accumulators, texture store.
// A texel write is stored as it is accepted, a span start loads the accumulators in
// S_PRE. A shade request computes u and then v on one shared 40-step bit-serial
// divider: each coordinate is a quotient by 1/z followed by a remainder by the
// texture size; then S_READ reads the texture store and S_OUT loads the result.
// A nonpositive 1/z skips the divider, a negative u/z skips both u divisions and a
// negative v/z skips the v remainder.
// The result sits in an output register; further requests are taken while it waits,
// and a following shade holds in its last cycle until the waiting result is taken.
// Texture store contents are undefined until written.
module perspective_texture_span #(
  parameter int MAX_TEXTURE_DIM = 128,
  parameter int TEXEL_DEPTH = 16384
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pts_pkg::in_t      in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pts_pkg::out_t     out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);
  import pts_pkg::*;

  localparam int AW = $clog2(TEXEL_DEPTH);
  localparam int DW = $clog2(MAX_TEXTURE_DIM + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_PRE  = 3'd1;
  localparam logic [2:0] S_DIVU = 3'd2;
  localparam logic [2:0] S_DIVV = 3'd3;
  localparam logic [2:0] S_READ = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;
  localparam logic [2:0] S_MODU = 3'd6;
  localparam logic [2:0] S_MODV = 3'd7;

  logic [2:0] state;
  logic [31:0] ooz_step, uoz_step, voz_step;
  logic [7:0] tex_w, tex_h;
  logic [31:0] acc_ooz, acc_uoz, acc_voz;
  in_t req;
  logic fault;
  logic [DW-1:0] u, v;
  logic [DW-1:0] w_c, h_c;
  logic div_start, div_busy;
  logic [39:0] div_num, div_q;
  logic [31:0] div_den, div_rem;
  logic [AW-1:0] raddr;
  logic [23:0] rdata;
  logic [47:0] pre_o, pre_u, pre_v;
  logic [DW-1:0] mod_dim;

  function automatic logic [DW-1:0] clamp_dim(input logic [7:0] d);
    if (d == 8'd0) begin
      return DW'(1);
    end else if (32'(d) > MAX_TEXTURE_DIM) begin
      return DW'(MAX_TEXTURE_DIM);
    end else begin
      return DW'(d);
    end
  endfunction

  function automatic logic [31:0] prestep(input logic [31:0] s, input logic [47:0] p);
    return s + p[47:16];
  endfunction

  assign w_c = clamp_dim(tex_w);
  assign h_c = clamp_dim(tex_h);
  assign in_ready = (state == S_IDLE);

  // divider operands: quotient by 1/z, then wrap by the texture size
  assign div_num = (state == S_DIVU) ? 40'(acc_uoz[30:0]) * 40'(w_c)
                 : (state == S_DIVV) ? 40'(acc_voz[30:0]) * 40'(h_c)
                 : div_q;
  assign mod_dim = (state == S_MODU) ? w_c : h_c;
  assign div_den = (state == S_MODU || state == S_MODV) ? 32'(mod_dim) : acc_ooz;

  pts_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_num),
    .divisor(div_den), .busy(div_busy), .quotient(div_q), .remainder(div_rem)
  );

  pts_ram #(.WIDTH(24), .DEPTH(TEXEL_DEPTH)) u_store (
    .clk(clk),
    .we(in_valid && in_ready && in_data.command == CMD_WRITE &&
        32'(in_data.texel_index) < TEXEL_DEPTH),
    .waddr(AW'(in_data.texel_index)), .wdata(in_data.texel_rgb),
    .raddr(raddr), .rdata(rdata)
  );

  logic [31:0] addr_full;
  assign addr_full = 32'(v) * 32'(w_c) + 32'(u);
  assign raddr = AW'(addr_full % TEXEL_DEPTH);

  logic div_go;

  always_ff @(posedge clk) begin
    pre_o <= 48'($signed(ooz_step)) * 48'($signed({1'b0, in_data.x_prestep}));
    pre_u <= 48'($signed(uoz_step)) * 48'($signed({1'b0, in_data.x_prestep}));
    pre_v <= 48'($signed(voz_step)) * 48'($signed({1'b0, in_data.x_prestep}));
  end

  assign div_start = div_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; out_valid <= 1'b0; div_go <= 1'b0;
      ooz_step <= '0; uoz_step <= '0; voz_step <= '0;
      tex_w <= 8'd128; tex_h <= 8'd128;
      acc_ooz <= '0; acc_uoz <= '0; acc_voz <= '0;
    end else begin
      div_go <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_OOZ_STEP: ooz_step <= cfg_data;
          REG_UOZ_STEP: uoz_step <= cfg_data;
          REG_VOZ_STEP: voz_step <= cfg_data;
          REG_WIDTH:    tex_w <= cfg_data[7:0];
          REG_HEIGHT:   tex_h <= cfg_data[7:0];
          default: ;
        endcase
      end
      if (state == S_OUT && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: if (in_valid && in_ready) begin
          req <= in_data;
          if (in_data.command == CMD_START) begin
            state <= S_PRE;
          end else if (in_data.command == CMD_SHADE) begin
            fault <= 1'b0; u <= '0; v <= '0;
            if ($signed(acc_ooz) <= 0) begin
              fault <= 1'b1; state <= S_READ;
            end else if (acc_uoz[31]) begin
              fault <= 1'b1; state <= S_DIVV; div_go <= 1'b1;
            end else begin
              state <= S_DIVU; div_go <= 1'b1;
            end
          end
        end
        S_PRE: begin
          acc_ooz <= prestep(req.start_one_over_z, pre_o);
          acc_uoz <= prestep(req.start_u_over_z, pre_u);
          acc_voz <= prestep(req.start_v_over_z, pre_v);
          state <= S_IDLE;
        end
        S_DIVU: if (!div_go && !div_busy) begin
          div_go <= 1'b1; state <= S_MODU;
        end
        S_MODU: if (!div_go && !div_busy) begin
          u <= DW'(div_rem);
          div_go <= 1'b1; state <= S_DIVV;
        end
        S_DIVV: if (!div_go && !div_busy) begin
          if (acc_voz[31]) begin
            fault <= 1'b1; state <= S_READ;
          end else begin
            div_go <= 1'b1; state <= S_MODV;
          end
        end
        S_MODV: if (!div_go && !div_busy) begin
          v <= DW'(div_rem);
          state <= S_READ;
        end
        S_READ: state <= S_OUT;
        S_OUT: if (!out_valid || out_ready) begin
          out_data.pixel_argb <= {ALPHA_OPAQUE, rdata};
          out_data.coordinate_fault <= fault;
          acc_ooz <= acc_ooz + ooz_step;
          acc_uoz <= acc_uoz + uoz_step;
          acc_voz <= acc_voz + voz_step;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst) (out_valid && !out_ready) |=> out_valid)
    else $error("pending result dropped");
  assert property (@(posedge clk) disable iff (rst) state == S_OUT |=> out_valid)
    else $error("shade produced no result");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> $stable(out_data))
    else $error("result changed while stalled");
endmodule

/* rtl/pts_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read.
module pts_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/pts_div.sv */
// Radix-2 restoring divider, unsigned 40-bit dividend by 32-bit divisor.
module pts_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [39:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [39:0] quotient,
  output logic [31:0] remainder
);
  logic [5:0]  count;
  logic [31:0] rem;
  logic [32:0] shifted;
  logic [32:0] trial;

  assign shifted   = {rem, quotient[39]};
  assign trial     = shifted - {1'b0, divisor};
  assign remainder = rem;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= 6'd40;
    end else if (busy) begin
      count <= count - 6'd1;
      if (count == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
    end else if (busy) begin
      if (!trial[32]) begin
        rem      <= trial[31:0];
        quotient <= {quotient[38:0], 1'b1};
      end else begin
        rem      <= shifted[31:0];
        quotient <= {quotient[38:0], 1'b0};
      end
    end
  end
endmodule

/* tb/sv/tb.sv */
// Testbench for the perspective texture span unit: directed and random requests, scoreboard.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import pts_pkg::*;

  localparam int DEPTH = 16384;
  localparam int MAXDIM = 128;
  localparam longint LIMIT = 3000000;
  localparam int IN_W = $bits(in_t);

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  perspective_texture_span i_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  logic [31:0] ooz_step, uoz_step, voz_step;
  logic [7:0] tex_w, tex_h;
  logic [31:0] span_ooz, span_uoz, span_voz;
  logic [23:0] texels [DEPTH];
  bit written [DEPTH];
  out_t pixel_queue [$];
  int errors = 0;
  int shaded = 0;
  int faults_seen = 0;
  longint cycles = 0;
  int hold_cycles = 0;
  bit stall_random = 1'b1;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("perspective_texture_span test failed");
      $finish;
    end
  end

  function automatic logic [31:0] prestep(logic [31:0] start, logic [31:0] step,
                                          logic [15:0] pre);
    longint prod;
    longint adj;
    prod = longint'($signed(step)) * longint'({1'b0, pre});
    adj = prod >>> 16;
    return start + adj[31:0];
  endfunction

  function automatic int eff_dim(logic [7:0] d);
    if (d == 0) return 1;
    if (d > MAXDIM) return MAXDIM;
    return int'(d);
  endfunction

  function automatic bit texel_readable(output int addr);
    int w, h;
    longint ooz, n, u, v;
    w = eff_dim(tex_w);
    h = eff_dim(tex_h);
    ooz = longint'($signed(span_ooz));
    u = 0;
    v = 0;
    if (ooz > 0) begin
      n = longint'($signed(span_uoz));
      if (n >= 0) u = ((n * w) / ooz) % w;
      n = longint'($signed(span_voz));
      if (n >= 0) v = ((n * h) / ooz) % h;
    end
    addr = int'((v * w + u) % DEPTH);
    return written[addr];
  endfunction

  function automatic out_t shade_pixel();
    out_t r;
    int addr;
    longint ooz;
    void'(texel_readable(addr));
    ooz = longint'($signed(span_ooz));
    r.coordinate_fault = (ooz <= 0) || ($signed(span_uoz) < 0) || ($signed(span_voz) < 0);
    r.pixel_argb = {ALPHA_OPAQUE, texels[addr]};
    span_ooz += ooz_step;
    span_uoz += uoz_step;
    span_voz += voz_step;
    return r;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    if (errors <= 30) $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  always @(posedge clk) begin
    out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pixel_queue.size() == 0) begin
        report("unexpected pixel", out_data.pixel_argb, 32'd0);
      end else begin
        want = pixel_queue.pop_front();
        if (out_data.pixel_argb !== want.pixel_argb)
          report("pixel_argb", out_data.pixel_argb, want.pixel_argb);
        if (out_data.coordinate_fault !== want.coordinate_fault)
          report("coordinate_fault", 32'(out_data.coordinate_fault),
                 32'(want.coordinate_fault));
        if (want.coordinate_fault) faults_seen++;
        shaded++;
      end
    end
  end

  int gap;
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else if (!stall_random) begin
      out_ready <= 1'b1;
    end else begin
      gap = $urandom_range(0, 99);
      out_ready <= (gap < 70) ? 1'b1 : (gap < 97) ? 1'b0 : ($urandom_range(0, 1) == 0);
    end
  end

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return;
    if (r < 95) repeat ($urandom_range(1, 3)) @(negedge clk);
    else repeat ($urandom_range(10, 60)) @(negedge clk);
  endtask

  task automatic send(in_t req);
    int addr;
    if (req.command == CMD_SHADE && !texel_readable(addr))
      send(write_req(addr, 24'($urandom)));
    in_data = req;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    case (req.command)
      CMD_WRITE: begin
        texels[req.texel_index] = req.texel_rgb;
        written[req.texel_index] = 1'b1;
      end
      CMD_START: begin
        span_ooz = prestep(req.start_one_over_z, ooz_step, req.x_prestep);
        span_uoz = prestep(req.start_u_over_z, uoz_step, req.x_prestep);
        span_voz = prestep(req.start_v_over_z, voz_step, req.x_prestep);
      end
      CMD_SHADE: pixel_queue.push_back(shade_pixel());
      default: ;
    endcase
    @(negedge clk);
    in_valid = 1'b0;
    if (stall_random) idle_gap();
  endtask

  task automatic drain();
    while (pixel_queue.size() != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic set_reg(logic [2:0] idx, logic [31:0] val);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_OOZ_STEP: ooz_step = val;
      REG_UOZ_STEP: uoz_step = val;
      REG_VOZ_STEP: voz_step = val;
      REG_WIDTH: tex_w = val[7:0];
      REG_HEIGHT: tex_h = val[7:0];
      default: ;
    endcase
  endtask

  function automatic in_t write_req(int idx, logic [23:0] rgb);
    in_t r;
    r = '0;
    r.command = CMD_WRITE;
    r.texel_index = idx[13:0];
    r.texel_rgb = rgb;
    return r;
  endfunction

  function automatic in_t start_req(logic [31:0] o, logic [31:0] u, logic [31:0] v,
                                    logic [15:0] pre);
    in_t r;
    r = in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    r.command = CMD_START;
    r.start_one_over_z = o;
    r.start_u_over_z = u;
    r.start_v_over_z = v;
    r.x_prestep = pre;
    return r;
  endfunction

  function automatic in_t shade_req();
    in_t r;
    r = in_t'(IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom}));
    r.command = CMD_SHADE;
    return r;
  endfunction

  task automatic fill_texture();
    for (int i = 0; i < MAXDIM; i++) send(write_req(i, 24'($urandom)));
  endtask

  task automatic test_directed();
    in_t r;
    send(write_req(0, 24'hFFFFFF));
    send(write_req(DEPTH - 1, 24'h000000));
    send(write_req(5, 24'hA5C3E1));
    send(start_req(32'h0100_0000, 32'd0, 32'd0, 16'd0));
    send(shade_req());
    send(start_req(32'd0, 32'd0, 32'd0, 16'hFFFF));
    send(shade_req());
    send(start_req(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF));
    send(shade_req());
    r = start_req(32'h0100_0000, 32'hFF00_0000, 32'h0000_0000, 16'd0);
    send(r);
    send(shade_req());
    r = '0;
    r.command = CMD_UNUSED;
    send(r);
    drain();
  endtask

  task automatic test_config_and_prestep();
    set_reg(REG_OOZ_STEP, 32'h8000_0000);
    set_reg(REG_UOZ_STEP, 32'h7FFF_FFFF);
    set_reg(REG_VOZ_STEP, 32'hFFFF_FFFF);
    set_reg(REG_WIDTH, 32'd0);
    set_reg(REG_HEIGHT, 32'd255);
    send(start_req(32'h7FFF_FFFF, 32'h0123_4567, 32'h0765_4321, 16'hFFFF));
    send(shade_req());
    send(shade_req());
    send(start_req(32'h0080_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8001));
    send(shade_req());
    drain();
  endtask

  task automatic random_phase(int spans);
    int len;
    for (int s = 0; s < spans; s++) begin
      if ($urandom_range(0, 9) == 0) send(write_req($urandom, 24'($urandom)));
      if ($urandom_range(0, 19) == 0) send(start_req($urandom, $urandom, $urandom,
                                                      16'($urandom)));
      else send(start_req($urandom_range(1, 32'h0400_0000), $urandom_range(0, 32'h0800_0000)
                          - ($urandom_range(0, 7) == 0 ? 32'h0010_0000 : 0),
                          $urandom_range(0, 32'h0800_0000), 16'($urandom)));
      len = $urandom_range(1, 8);
      for (int p = 0; p < len; p++) send(shade_req());
    end
  endtask

  task automatic test_random();
    logic [7:0] dims [6] = '{8'd1, 8'd128, 8'd7, 8'd64, 8'd129, 8'd33};
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      set_reg(REG_OOZ_STEP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h4000)
                            - 32'h2000);
      set_reg(REG_UOZ_STEP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40000));
      set_reg(REG_VOZ_STEP, $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h40000));
      set_reg(REG_WIDTH, 32'(dims[ph]));
      set_reg(REG_HEIGHT, 32'(dims[5 - ph]));
      random_phase(25);
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_cycles = 600;
    for (int i = 0; i < 12; i++) send(shade_req());
    drain();
    stall_random = 1'b0;
    random_phase(10);
    drain();
    stall_random = 1'b1;
  endtask

  initial begin
    ooz_step = 0; uoz_step = 0; voz_step = 0;
    tex_w = 8'd128; tex_h = 8'd128;
    span_ooz = 0; span_uoz = 0; span_voz = 0;
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    test_config_and_prestep();
    fill_texture();
    test_random();
    test_backpressure();
    drain();
    $display("shaded %0d pixels (%0d with coordinate fault) over several texture sizes",
             shaded, faults_seen);
    $display("and gradient settings, with random stalls on both sides");
    if (errors == 0 && pixel_queue.size() == 0) begin
      $display("perspective_texture_span test passed");
    end else begin
      $display("perspective_texture_span test failed");
    end
    $finish;
  end
endmodule

/* files.f */
rtl/pts_pkg.sv
rtl/pts_ram.sv
rtl/pts_div.sv
rtl/perspective_texture_span.sv
tb/sv/tb.sv
